@@ src/array_min_priority_queue_defines.svh @@
// assertion macros for the array min priority queue checker
// no dependencies; included by the checker file only
`ifndef ARRAY_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define ARRAY_MIN_PRIORITY_QUEUE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define APQ_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define APQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/apq_pkg.sv @@
// shared constants, codes and types of the array min priority queue
// no dependencies
package apq_pkg;

	localparam int MAX_VERTICES = 1023;
	localparam int SLOTS        = MAX_VERTICES + 1;
	localparam int VTX_W        = $clog2(SLOTS);
	localparam int KEY_W        = 32;
	localparam int ENTRY_W      = KEY_W + 1;

	localparam logic [VTX_W-1:0] MAX_VTX   = VTX_W'(MAX_VERTICES);
	localparam logic [VTX_W-1:0] LAST_SLOT = VTX_W'(SLOTS - 1);

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_DEC  = 2'd1;
	localparam logic [1:0] CMD_DEL  = 2'd2;

	// status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// one candidate word from the memory scan
	typedef struct packed {
		logic             clear;
		logic             valid;
		logic             member;
		logic [VTX_W-1:0] idx;
		logic             inf;
		logic [KEY_W-1:0] key;
	} cand_t;

	// running winner of the scan
	typedef struct packed {
		logic             found;
		logic [VTX_W-1:0] idx;
	} best_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_BUILD  = 7'b0000100,
		S_SCAN   = 7'b0001000,
		S_DRAIN  = 7'b0010000,
		S_REMOVE = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

endpackage

@@ src/apq_if.sv @@
// valid/ready channel interfaces: command items, result words, configuration
// depends on apq_pkg
interface apq_item_if import apq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       cmd;
	logic [VTX_W-1:0] vertex;
	logic [KEY_W-1:0] key;
	logic             key_infinite;

	modport source (output valid, cmd, vertex, key, key_infinite, input ready);
	modport sink (input valid, cmd, vertex, key, key_infinite, output ready);
endinterface

interface apq_result_if import apq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             status;
	logic [VTX_W-1:0] min_vertex;
	logic [VTX_W-1:0] queue_size;

	modport source (output valid, status, min_vertex, queue_size, input ready);
	modport sink (input valid, status, min_vertex, queue_size, output ready);
endinterface

interface apq_cfg_if import apq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VTX_W-1:0] vertex_count;

	modport source (output valid, vertex_count, input ready);
	modport sink (input valid, vertex_count, output ready);
endinterface

@@ src/apq_ram.sv @@
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module apq_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/apq_min_track.sv @@
// running minimum of the delete-min scan: infinite loses, ties keep lower index
// depends on apq_pkg
module apq_min_track import apq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cand_t cand,
	output best_t best
);

	logic             found_q;
	logic [VTX_W-1:0] idx_q;
	logic             inf_q;
	logic [KEY_W-1:0] key_q;
	logic             ranks_first;
	logic             take;

	// rank compare against the held winner
	always_comb begin
		ranks_first = !cand.inf && (inf_q || ($signed(cand.key) < $signed(key_q)));
		take        = cand.valid && cand.member && (!found_q || ranks_first);
	end

	// winner flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cand.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// winner payload
	always_ff @(posedge clk) begin
		if (take && !cand.clear) begin
			idx_q <= cand.idx;
			inf_q <= cand.inf;
			key_q <= cand.key;
		end
	end

	assign best.found = found_q;
	assign best.idx   = idx_q;

endmodule

@@ src/array_min_priority_queue.sv @@
// array min priority queue, one item at a time, one result word per item.
// a build writes one membership word per slot, a delete minimum reads one
// key and membership word per vertex, and an empty queue skips the scan.
// throughput: next item taken the cycle after its result word is registered.
// reset clears control, size and output; memories keep contents and
// membership reads as empty until the first build, so no clearing pass.
module array_min_priority_queue import apq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	apq_cfg_if.sink    cfg,
	apq_item_if.sink   item,
	apq_result_if.source result
);

	state_t           state_q;
	logic [VTX_W-1:0] vertex_count_q;
	logic [VTX_W-1:0] count_q;
	logic             built_q;
	logic [VTX_W-1:0] ptr_q;
	logic [VTX_W-1:0] vertex_q;
	logic [KEY_W-1:0] key_q;
	logic             inf_q;
	logic             res_status_q;
	logic [VTX_W-1:0] res_min_q;
	logic             rd_vld_s1;
	logic [VTX_W-1:0] rd_idx_s1;
	logic             out_valid_q;
	logic             out_status_q;
	logic [VTX_W-1:0] out_min_q;
	logic [VTX_W-1:0] out_size_q;

	logic               item_acc;
	logic [VTX_W-1:0]   lim;
	logic               load_ok;
	logic               member;
	logic               out_free;
	logic               key_we;
	logic [VTX_W-1:0]   key_waddr;
	logic [ENTRY_W-1:0] key_wdata;
	logic [ENTRY_W-1:0] key_rdata;
	logic               flag_we;
	logic [VTX_W-1:0]   flag_waddr;
	logic               flag_wdata;
	logic               flag_re;
	logic [VTX_W-1:0]   flag_raddr;
	logic               flag_rdata;
	cand_t              cand;
	best_t              best;

	// handshakes
	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	// build limit and membership of the word just read
	always_comb begin
		lim     = (vertex_count_q > MAX_VTX) ? MAX_VTX : vertex_count_q;
		load_ok = (item.vertex == '0) || (item.vertex <= lim);
		member  = built_q && flag_rdata;
	end

	// key memory port control
	always_comb begin
		if (state_q == S_CHECK) begin
			key_we    = member;
			key_waddr = vertex_q;
			key_wdata = {inf_q, key_q};
		end else begin
			key_we    = item_acc && (item.cmd == CMD_LOAD) && load_ok;
			key_waddr = item.vertex;
			key_wdata = {item.key_infinite, item.key};
		end
	end

	// membership memory port control
	always_comb begin
		flag_re    = (state_q == S_SCAN) || (item_acc && (item.cmd == CMD_DEC));
		flag_raddr = (state_q == S_SCAN) ? ptr_q : item.vertex;
		if (state_q == S_BUILD) begin
			flag_we    = 1'b1;
			flag_waddr = ptr_q;
			flag_wdata = (ptr_q != '0) && (ptr_q <= lim);
		end else begin
			flag_we    = (state_q == S_REMOVE) && best.found;
			flag_waddr = best.idx;
			flag_wdata = 1'b0;
		end
	end

	apq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.re   (state_q == S_SCAN),
		.raddr(ptr_q),
		.rdata(key_rdata)
	);

	apq_ram #(
		.WIDTH(1),
		.DEPTH(SLOTS)
	) u_flag_ram (
		.clk  (clk),
		.we   (flag_we),
		.waddr(flag_waddr),
		.wdata(flag_wdata),
		.re   (flag_re),
		.raddr(flag_raddr),
		.rdata(flag_rdata)
	);

	// scan candidate into the minimum tracker
	always_comb begin
		cand.clear  = item_acc;
		cand.valid  = rd_vld_s1;
		cand.member = member;
		cand.idx    = rd_idx_s1;
		cand.inf    = key_rdata[KEY_W];
		cand.key    = key_rdata[KEY_W-1:0];
	end

	apq_min_track u_min_track (
		.clk   (clk),
		.arst_n(arst_n),
		.cand  (cand),
		.best  (best)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			vertex_count_q <= cfg.vertex_count;
		end
	end

	// captured item payload
	always_ff @(posedge clk) begin
		if (item_acc) begin
			vertex_q <= item.vertex;
			key_q    <= item.key;
			inf_q    <= item.key_infinite;
		end
	end

	// scan read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			built_q      <= 1'b0;
			ptr_q        <= '0;
			res_status_q <= STATUS_OK;
			res_min_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						res_min_q <= '0;
						case (item.cmd)
							CMD_LOAD: begin
								if (item.vertex == '0) begin
									ptr_q   <= '0;
									state_q <= S_BUILD;
								end else begin
									res_status_q <= load_ok ? STATUS_OK : STATUS_BAD;
									state_q      <= S_DONE;
								end
							end
							CMD_DEC: begin
								state_q <= S_CHECK;
							end
							CMD_DEL: begin
								if (count_q == '0) begin
									res_status_q <= STATUS_BAD;
									state_q      <= S_DONE;
								end else begin
									ptr_q   <= VTX_W'(1);
									state_q <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= STATUS_BAD;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_CHECK: begin
					res_status_q <= member ? STATUS_OK : STATUS_BAD;
					state_q      <= S_DONE;
				end
				S_BUILD: begin
					ptr_q <= ptr_q + VTX_W'(1);
					if (ptr_q == LAST_SLOT) begin
						count_q      <= lim;
						built_q      <= 1'b1;
						res_status_q <= STATUS_OK;
						state_q      <= S_DONE;
					end
				end
				S_SCAN: begin
					ptr_q <= ptr_q + VTX_W'(1);
					if (ptr_q == MAX_VTX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_REMOVE;
				end
				S_REMOVE: begin
					if (best.found) begin
						count_q      <= count_q - VTX_W'(1);
						res_min_q    <= best.idx;
						res_status_q <= STATUS_OK;
					end else begin
						res_status_q <= STATUS_BAD;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_OK;
			out_min_q    <= '0;
			out_size_q   <= '0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q  <= 1'b1;
			out_status_q <= res_status_q;
			out_min_q    <= res_min_q;
			out_size_q   <= count_q;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.status     = out_status_q;
	assign result.min_vertex = out_min_q;
	assign result.queue_size = out_size_q;

endmodule

@@ src/apq_checker.sv @@
// port-level checker for the array min priority queue, bound to the top level
// depends on apq_pkg and array_min_priority_queue_defines.svh
`include "array_min_priority_queue_defines.svh"

module apq_checker import apq_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic             res_status,
	input logic [VTX_W-1:0] res_min_vertex,
	input logic [VTX_W-1:0] res_queue_size
);

	// a stalled result word stays offered
	`APQ_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result word dropped while stalled")

	// a stalled result word keeps its payload
	`APQ_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_status) && $stable(res_min_vertex) && $stable(res_queue_size), "result word changed while stalled")

	// one item at a time: ready drops right after an accepted item
	`APQ_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, item_valid && item_ready, !item_ready, "second item taken before result")

	// a removed vertex is only reported with ok status
	`APQ_ASSERT_SAME(a_min_needs_ok, clk, arst_n, res_valid && (res_min_vertex != '0), res_status == STATUS_OK, "min vertex with bad status")

endmodule

bind array_min_priority_queue apq_checker u_apq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_status    (result.status),
	.res_min_vertex(result.min_vertex),
	.res_queue_size(result.queue_size)
);

@@ test/tb_array_min_priority_queue.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the array min priority queue: a directed table, then random phases
// keeps its own copy of the queue state to predict every result word
// depends on apq_pkg, the channel interfaces in apq_if.sv and the queue rtl
module tb_array_min_priority_queue;
	import apq_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int RANDOM_OPS        = 580;
	localparam int WATCHDOG_LIMIT    = 20000;
	localparam int SETTLE_CYCLES     = 1100;

	typedef struct packed {
		logic             status;
		logic [VTX_W-1:0] min_vertex;
		logic [VTX_W-1:0] queue_size;
	} queue_reply_t;

	typedef enum bit {ROW_CFG, ROW_OP} row_kind_t;

	// one row of the directed table; vertex holds the count on a config row
	typedef struct packed {
		row_kind_t        kind;
		logic [1:0]       op;
		logic [VTX_W-1:0] vertex;
		logic [KEY_W-1:0] key;
		logic             inf;
		bit               typed;
		queue_reply_t     reply;
	} directed_row_t;

	localparam queue_reply_t UNTYPED = '{1'b0, 10'd0, 10'd0};

	localparam directed_row_t DIRECTED_ROWS [30] = '{
		// empty queue after reset
		'{ROW_CFG, CMD_LOAD,  10'd0,    32'h0,        1'b0, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_DEL,   10'd0,    32'h0,        1'b0, 1'b1, '{STATUS_BAD, 10'd0, 10'd0}},
		'{ROW_OP,  CMD_DEC,   10'd5,    32'h1,        1'b0, 1'b1, '{STATUS_BAD, 10'd0, 10'd0}},
		'{ROW_OP,  CMD_SPARE, 10'd7,    32'h12345678, 1'b1, 1'b1, '{STATUS_BAD, 10'd0, 10'd0}},
		'{ROW_OP,  CMD_LOAD,  10'd3,    32'h9,        1'b0, 1'b1, '{STATUS_BAD, 10'd0, 10'd0}},
		'{ROW_OP,  CMD_LOAD,  10'd0,    32'h0,        1'b0, 1'b1, '{STATUS_OK, 10'd0, 10'd0}},
		// four members: key extremes, infinite key, equal keys
		'{ROW_CFG, CMD_LOAD,  10'd4,    32'h0,        1'b0, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_LOAD,  10'd0,    32'hFFFFFFFF, 1'b1, 1'b1, '{STATUS_OK, 10'd0, 10'd4}},
		'{ROW_OP,  CMD_LOAD,  10'd1,    32'h7FFFFFFF, 1'b0, 1'b1, '{STATUS_OK, 10'd0, 10'd4}},
		'{ROW_OP,  CMD_LOAD,  10'd2,    32'h80000000, 1'b0, 1'b1, '{STATUS_OK, 10'd0, 10'd4}},
		'{ROW_OP,  CMD_LOAD,  10'd3,    32'h0,        1'b1, 1'b1, '{STATUS_OK, 10'd0, 10'd4}},
		'{ROW_OP,  CMD_LOAD,  10'd4,    32'h80000000, 1'b0, 1'b1, '{STATUS_OK, 10'd0, 10'd4}},
		'{ROW_OP,  CMD_LOAD,  10'd5,    32'h0,        1'b0, 1'b1, '{STATUS_BAD, 10'd0, 10'd4}},
		'{ROW_OP,  CMD_DEC,   10'd1023, 32'h0,        1'b0, 1'b1, '{STATUS_BAD, 10'd0, 10'd4}},
		'{ROW_OP,  CMD_DEL,   10'd0,    32'h0,        1'b0, 1'b1, '{STATUS_OK, 10'd2, 10'd3}},
		'{ROW_OP,  CMD_DEL,   10'd0,    32'h0,        1'b0, 1'b1, '{STATUS_OK, 10'd4, 10'd2}},
		'{ROW_OP,  CMD_DEC,   10'd3,    32'h5,        1'b0, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_DEC,   10'd2,    32'h0,        1'b0, 1'b1, '{STATUS_BAD, 10'd0, 10'd2}},
		'{ROW_OP,  CMD_DEL,   10'd0,    32'h0,        1'b0, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_DEL,   10'd0,    32'h0,        1'b0, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_DEL,   10'd0,    32'h0,        1'b0, 1'b1, '{STATUS_BAD, 10'd0, 10'd0}},
		// full table
		'{ROW_CFG, CMD_LOAD,  10'd1023, 32'h0,        1'b0, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_LOAD,  10'd0,    32'h0,        1'b0, 1'b1, '{STATUS_OK, 10'd0, 10'd1023}},
		'{ROW_OP,  CMD_LOAD,  10'd1023, 32'hFFFFFFFF, 1'b0, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_DEC,   10'd1023, 32'h0,        1'b1, 1'b0, UNTYPED},
		// two infinite keys, lower index wins
		'{ROW_CFG, CMD_LOAD,  10'd2,    32'h0,        1'b0, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_LOAD,  10'd0,    32'h0,        1'b0, 1'b1, '{STATUS_OK, 10'd0, 10'd2}},
		'{ROW_OP,  CMD_DEC,   10'd1,    32'h0,        1'b1, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_DEC,   10'd2,    32'h0,        1'b1, 1'b0, UNTYPED},
		'{ROW_OP,  CMD_DEL,   10'd0,    32'h0,        1'b0, 1'b0, UNTYPED}
	};

	logic clk;
	logic arst_n;

	apq_cfg_if    cfg_ch ();
	apq_item_if   item_ch ();
	apq_result_if result_ch ();

	array_min_priority_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	// shadow of the queue state
	logic signed [KEY_W-1:0] key_mem [0:MAX_VERTICES];
	bit                      inf_mem [0:MAX_VERTICES];
	bit                      member_flag [0:MAX_VERTICES];
	bit                      key_loaded [0:MAX_VERTICES];
	int unsigned             member_total;
	logic [VTX_W-1:0]        count_reg;

	queue_reply_t replies_due [$];
	int unsigned  mismatches;
	int unsigned  ops_sent;
	int unsigned  stalled_cycles;
	bit           src_steady;
	bit           sink_steady;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit outranks(input int unsigned a, input int unsigned b);
		if (inf_mem[a])
			return 1'b0;
		if (inf_mem[b])
			return 1'b1;
		return key_mem[a] < key_mem[b];
	endfunction

	// next state and result word of one queue operation
	function automatic queue_reply_t apply_queue_op(input logic [1:0] op,
			input logic [VTX_W-1:0] v, input logic [KEY_W-1:0] k, input logic inf);
		queue_reply_t r;
		int unsigned  lim;
		int unsigned  best;
		r = '{STATUS_OK, '0, '0};
		lim = (count_reg > MAX_VTX) ? MAX_VERTICES : count_reg;
		case (op)
			CMD_LOAD: begin
				if (v == 0) begin
					key_mem[0] = k;
					inf_mem[0] = inf;
					key_loaded[0] = 1'b1;
					foreach (member_flag[i])
						member_flag[i] = (i >= 1 && i <= lim);
					member_total = lim;
				end else if (v <= lim) begin
					key_mem[v] = k;
					inf_mem[v] = inf;
					key_loaded[v] = 1'b1;
				end else begin
					r.status = STATUS_BAD;
				end
			end
			CMD_DEC: begin
				if (member_flag[v]) begin
					key_mem[v] = k;
					inf_mem[v] = inf;
					key_loaded[v] = 1'b1;
				end else begin
					r.status = STATUS_BAD;
				end
			end
			CMD_DEL: begin
				best = 0;
				for (int unsigned i = 1; i <= MAX_VERTICES; i++)
					if (member_flag[i] && (best == 0 || outranks(i, best)))
						best = i;
				if (member_total == 0 || best == 0) begin
					r.status = STATUS_BAD;
				end else begin
					member_flag[best] = 1'b0;
					member_total--;
					r.min_vertex = VTX_W'(best);
				end
			end
			default: r.status = STATUS_BAD;
		endcase
		r.queue_size = VTX_W'(member_total);
		return r;
	endfunction

	// a delete may only scan members whose key was written
	function automatic bit all_members_loaded();
		for (int unsigned i = 1; i <= MAX_VERTICES; i++)
			if (member_flag[i] && !key_loaded[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [VTX_W-1:0] any_member();
		int unsigned start;
		int unsigned idx;
		start = $urandom_range(1, MAX_VERTICES);
		for (int unsigned i = 0; i < MAX_VERTICES; i++) begin
			idx = ((start - 1 + i) % MAX_VERTICES) + 1;
			if (member_flag[idx])
				return VTX_W'(idx);
		end
		return '0;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return KEY_W'($signed($urandom_range(0, 6)) - 3);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic rand_inf();
		return $urandom_range(0, 5) == 0;
	endfunction

	// random gap, with stretches of back-to-back words
	function automatic int unsigned draw_gap(inout bit steady);
		if ($urandom_range(0, 31) == 0)
			steady = !steady;
		return steady ? 0 : $urandom_range(0, 15);
	endfunction

	// offer one command word and record its prediction once taken
	task automatic send_op(input logic [1:0] op, input logic [VTX_W-1:0] v,
			input logic [KEY_W-1:0] k, input logic inf,
			input bit typed = 1'b0, input queue_reply_t want = UNTYPED);
		int unsigned  gap;
		queue_reply_t predicted;
		gap = draw_gap(src_steady);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.cmd          <= op;
		item_ch.vertex       <= v;
		item_ch.key          <= k;
		item_ch.key_infinite <= inf;
		do @(posedge clk); while (!item_ch.ready);
		predicted = apply_queue_op(op, v, k, inf);
		replies_due.push_back(typed ? want : predicted);
		ops_sent++;
	endtask

	// register write once every result word is back
	task automatic write_count(input logic [VTX_W-1:0] n);
		item_ch.valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.vertex_count <= n;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		count_reg = n;
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 4))
			0: send_op(CMD_DEC, VTX_W'($urandom_range(0, MAX_VERTICES)), rand_key(), rand_inf());
			1: send_op(CMD_LOAD, VTX_W'($urandom_range(0, MAX_VERTICES)), rand_key(), rand_inf());
			2: send_op(CMD_SPARE, VTX_W'($urandom()), $urandom(), 1'($urandom()));
			3: send_op(CMD_LOAD, '0, rand_key(), rand_inf());
			default: begin
				if (all_members_loaded())
					send_op(CMD_DEL, VTX_W'($urandom()), $urandom(), 1'($urandom()));
				else
					send_op(CMD_SPARE, '0, '0, 1'b0);
			end
		endcase
	endtask

	// build, load keys, then a mix of deletes, decreases, loads and noise
	task automatic run_random_phases();
		int unsigned      n;
		int unsigned      steps;
		int unsigned      sel;
		logic [VTX_W-1:0] v;
		ops_sent = 0;
		while (ops_sent < RANDOM_OPS) begin
			sel = $urandom_range(0, 99);
			if (sel < 10)
				n = 0;
			else if (sel < 18)
				n = MAX_VERTICES;
			else if (sel < 28)
				n = 1;
			else
				n = $urandom_range(2, 24);
			write_count(VTX_W'(n));
			send_op(CMD_LOAD, '0, rand_key(), rand_inf());
			if (n <= 64) begin
				for (int unsigned i = 1; i <= n; i++)
					if (!key_loaded[i] || $urandom_range(0, 2) == 0)
						send_op(CMD_LOAD, VTX_W'(i), rand_key(), rand_inf());
				steps = $urandom_range(n + 2, 2 * n + 6);
			end else begin
				steps = $urandom_range(10, 25);
			end
			repeat (steps) begin
				sel = $urandom_range(0, 99);
				if (sel < 45 && member_total != 0 && all_members_loaded()) begin
					send_op(CMD_DEL, VTX_W'($urandom()), $urandom(), 1'($urandom()));
				end else if (sel < 75 && member_total != 0) begin
					v = any_member();
					send_op(CMD_DEC, v, rand_key(), rand_inf());
				end else if (sel < 85 && count_reg != 0) begin
					v = VTX_W'($urandom_range(1, count_reg));
					send_op(CMD_LOAD, v, rand_key(), rand_inf());
				end else begin
					send_noise();
				end
			end
		end
	endtask

	// compare one result word with the oldest prediction
	task automatic check_reply();
		queue_reply_t want;
		if (replies_due.size() == 0) begin
			$display("%0t: unexpected result word status %0d min_vertex %0d queue_size %0d",
				$time, result_ch.status, result_ch.min_vertex, result_ch.queue_size);
			mismatches++;
		end else begin
			want = replies_due.pop_front();
			if (result_ch.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status,
					result_ch.status);
				mismatches++;
			end
			if (result_ch.min_vertex !== want.min_vertex) begin
				$display("%0t: min_vertex expected %0d got %0d", $time, want.min_vertex,
					result_ch.min_vertex);
				mismatches++;
			end
			if (result_ch.queue_size !== want.queue_size) begin
				$display("%0t: queue_size expected %0d got %0d", $time, want.queue_size,
					result_ch.queue_size);
				mismatches++;
			end
		end
	endtask

	// result side: stalls land while a word is waiting
	initial begin
		int unsigned stall;
		result_ch.ready = 1'b1;
		sink_steady = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = draw_gap(sink_steady);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				do @(posedge clk); while (!result_ch.valid);
				repeat (stall - 1) @(posedge clk);
				result_ch.ready <= 1'b1;
			end
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
			check_reply();
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
				|| (result_ch.valid && result_ch.ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles == WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// reset, directed table, random phases, drain
	initial begin
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.cmd          = CMD_LOAD;
		item_ch.vertex       = '0;
		item_ch.key          = '0;
		item_ch.key_infinite = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.vertex_count  = '0;
		mismatches           = 0;
		src_steady           = 1'b0;
		member_total         = 0;
		count_reg            = '0;
		foreach (member_flag[i]) begin
			member_flag[i] = 1'b0;
			key_loaded[i]  = 1'b0;
			inf_mem[i]     = 1'b0;
			key_mem[i]     = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].kind == ROW_CFG)
				write_count(DIRECTED_ROWS[i].vertex);
			else
				send_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].vertex, DIRECTED_ROWS[i].key,
					DIRECTED_ROWS[i].inf, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].reply);
		end

		run_random_phases();

		item_ch.valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
